>>> sv/ptrel_pkg.sv
// shared constants, types and codes for the periodic task release engine
// no dependencies; imported by ptrel_mod_unit, periodic_task_release_with_precedence, release_checker and tb
package ptrel_pkg;

    localparam int TASK_COUNT      = 6;
    localparam int PERIOD_BITS     = 8;
    localparam int ACTIVATION_BITS = 16;

    localparam int TICK_BITS    = 32;
    localparam int PRED_BITS    = 3;
    localparam int ACTIVE_BITS  = 3;
    localparam int IDX_W        = $clog2(TASK_COUNT);
    localparam int CNT_W        = $clog2(TASK_COUNT + 1);
    localparam int TABLE_W      = TASK_COUNT * PERIOD_BITS;
    localparam int PRED_TABLE_W = TASK_COUNT * PRED_BITS;
    localparam int CFG_DATA_W   = (TABLE_W > PRED_TABLE_W) ? TABLE_W : PRED_TABLE_W;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [PRED_BITS-1:0] NO_PRED = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRED   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE = 2'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_DONE = 1'b1;

    // remainder unit: bits retired per cycle
    localparam int MOD_STEP   = 4;
    localparam int MOD_CYCLES = TICK_BITS / MOD_STEP;
    localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WAIT  = 2'd1,
        ST_READY = 2'd2
    } task_status_t;

    typedef struct packed {
        logic                   done;
        logic [PERIOD_BITS-1:0] remainder;
    } mod_rsp_t;

endpackage

>>> sv/periodic_task_release_with_precedence.sv
// Top level of the periodic task release engine with one-level precedence.
// A tick word runs each of the n active tasks (n the clamped active count) through the shared
// remainder unit, then makes n precedence passes, each pass visiting the n tasks in turn.
// busy stays high until the result is shown; done pulses once.
// Asynchronous active-low reset clears tables, tick counter, status, done marks and counts.
// Depends on ptrel_pkg and ptrel_mod_unit.
module periodic_task_release_with_precedence
    import ptrel_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  logic                       opcode,
    input  logic [2:0]                 task_index,
    output logic                       done,
    output logic [TASK_COUNT-1:0]      ready_mask,
    output logic [TASK_COUNT-1:0]      waiting_mask,
    output logic [TASK_COUNT-1:0]      released_mask,
    output logic [TICK_BITS-1:0]       tick_count,
    output logic [ACTIVATION_BITS-1:0] activation_total
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_PASS,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [TASK_COUNT-1:0][PERIOD_BITS-1:0] period_reg;
    logic [TASK_COUNT-1:0][PERIOD_BITS-1:0] phase_reg;
    logic [TASK_COUNT-1:0][PRED_BITS-1:0]   pred_reg;
    logic [ACTIVE_BITS-1:0]                 active_reg;

    logic [TICK_BITS-1:0]       tick_reg, tick_next;
    task_status_t               status_reg [TASK_COUNT];
    task_status_t               status_next [TASK_COUNT];
    logic [TASK_COUNT-1:0]      mark_reg, mark_next;
    logic [ACTIVATION_BITS-1:0] count_reg [TASK_COUNT];
    logic [ACTIVATION_BITS-1:0] count_next [TASK_COUNT];

    logic [TASK_COUNT-1:0]      rel_reg, rel_next;
    logic [TASK_COUNT-1:0]      relmask_reg, relmask_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           pass_reg, pass_next;
    logic                       mod_start_reg, mod_start_next;

    logic                       done_reg, done_next;
    logic [TASK_COUNT-1:0]      ready_reg, ready_next;
    logic [TASK_COUNT-1:0]      wait_reg, wait_next;
    logic [TASK_COUNT-1:0]      released_reg, released_next;
    logic [ACTIVATION_BITS-1:0] act_reg, act_next;

    logic [CNT_W-1:0]           n_clamp;
    logic                       idx_last;
    logic                       pass_last;
    logic [PRED_BITS-1:0]       pred_cur;
    logic [IDX_W-1:0]           pred_idx;
    logic                       has_pred;
    logic [IDX_W-1:0]           cidx;
    mod_rsp_t                   mod_rsp;

    assign n_clamp   = (int'(active_reg) > TASK_COUNT) ? CNT_W'(TASK_COUNT) : CNT_W'(active_reg);
    assign idx_last  = (CNT_W'(idx_reg) == n_clamp - CNT_W'(1));
    assign pass_last = (CNT_W'(pass_reg) == n_clamp - CNT_W'(1));
    assign pred_cur  = pred_reg[idx_reg];
    assign pred_idx  = pred_cur[IDX_W-1:0];
    assign has_pred  = (pred_cur != NO_PRED) && (int'(pred_cur) < int'(n_clamp));
    assign cidx      = task_index[IDX_W-1:0];

    ptrel_mod_unit u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start_reg),
        .dividend (tick_reg),
        .divisor  (period_reg[idx_reg]),
        .rsp      (mod_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        status_next    = status_reg;
        mark_next      = mark_reg;
        count_next     = count_reg;
        rel_next       = rel_reg;
        relmask_next   = relmask_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        mod_start_next = 1'b0;
        done_next      = 1'b0;
        ready_next     = ready_reg;
        wait_next      = wait_reg;
        released_next  = released_reg;
        act_next       = act_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    relmask_next = '0;
                    act_next     = '0;
                    if (opcode == OP_TICK)
                    begin
                        tick_next = tick_reg + TICK_BITS'(1);
                        rel_next  = '0;
                        idx_next  = '0;
                        pass_next = '0;
                        if (n_clamp == '0)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            mod_start_next = 1'b1;
                            state_next     = S_MOD;
                        end
                    end
                    else
                    begin
                        if (int'(task_index) < TASK_COUNT)
                        begin
                            status_next[cidx] = ST_IDLE;
                            mark_next[cidx]   = 1'b1;
                            if (count_reg[cidx] != '1)
                            begin
                                count_next[cidx] = count_reg[cidx] + ACTIVATION_BITS'(1);
                            end
                            act_next = count_next[cidx];
                        end
                        state_next = S_FINISH;
                    end
                end
            end

            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    if ((period_reg[idx_reg] != '0) && (mod_rsp.remainder == phase_reg[idx_reg]))
                    begin
                        rel_next[idx_reg]  = 1'b1;
                        mark_next[idx_reg] = 1'b0;
                        if (pred_cur == NO_PRED)
                        begin
                            status_next[idx_reg]  = ST_READY;
                            relmask_next[idx_reg] = 1'b1;
                        end
                    end
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = S_PASS;
                    end
                    else
                    begin
                        idx_next       = idx_reg + IDX_W'(1);
                        mod_start_next = 1'b1;
                    end
                end
            end

            S_PASS:
            begin
                if (rel_reg[idx_reg] && (pred_cur != NO_PRED))
                begin
                    if (has_pred)
                    begin
                        if ((status_reg[pred_idx] == ST_READY) || (status_reg[pred_idx] == ST_WAIT))
                        begin
                            status_next[idx_reg] = ST_WAIT;
                        end
                        else if (mark_reg[pred_idx])
                        begin
                            status_next[idx_reg]  = ST_READY;
                            relmask_next[idx_reg] = 1'b1;
                        end
                        else
                        begin
                            status_next[idx_reg] = ST_WAIT;
                        end
                    end
                end
                else if ((status_reg[idx_reg] == ST_WAIT) && has_pred && mark_reg[pred_idx])
                begin
                    status_next[idx_reg]  = ST_READY;
                    relmask_next[idx_reg] = 1'b1;
                end

                if (idx_last)
                begin
                    idx_next = '0;
                    if (pass_last)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        pass_next = pass_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_FINISH:
            begin
                for (int i = 0; i < TASK_COUNT; i++)
                begin
                    ready_next[i] = (status_reg[i] == ST_READY);
                    wait_next[i]  = (status_reg[i] == ST_WAIT);
                end
                released_next = relmask_reg & ready_next;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            period_reg    <= '0;
            phase_reg     <= '0;
            pred_reg      <= '1;
            active_reg    <= '0;
            tick_reg      <= '0;
            mark_reg      <= '0;
            rel_reg       <= '0;
            relmask_reg   <= '0;
            idx_reg       <= '0;
            pass_reg      <= '0;
            mod_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                status_reg[i] <= ST_IDLE;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            status_reg    <= status_next;
            mark_reg      <= mark_next;
            count_reg     <= count_next;
            rel_reg       <= rel_next;
            relmask_reg   <= relmask_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            mod_start_reg <= mod_start_next;
            done_reg      <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PERIOD: period_reg <= cfg_data[TABLE_W-1:0];
                    REG_PHASE:  phase_reg  <= cfg_data[TABLE_W-1:0];
                    REG_PRED:   pred_reg   <= cfg_data[PRED_TABLE_W-1:0];
                    REG_ACTIVE: active_reg <= cfg_data[ACTIVE_BITS-1:0];
                    default:    active_reg <= active_reg;
                endcase
            end
        end
    end

    // result word registers
    always_ff @(posedge clk)
    begin
        ready_reg    <= ready_next;
        wait_reg     <= wait_next;
        released_reg <= released_next;
        act_reg      <= act_next;
    end

    assign cfg_ready        = 1'b1;
    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign ready_mask       = ready_reg;
    assign waiting_mask     = wait_reg;
    assign released_mask    = released_reg;
    assign tick_count       = tick_reg;
    assign activation_total = act_reg;

endmodule

>>> sv/ptrel_mod_unit.sv
// iterative remainder unit: tick counter modulo a task period, several bits per cycle
// depends on ptrel_pkg
module ptrel_mod_unit
    import ptrel_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [TICK_BITS-1:0]   dividend,
    input  logic [PERIOD_BITS-1:0] divisor,
    output mod_rsp_t               rsp
);

    logic                   run_reg;
    logic                   done_reg;
    logic [MOD_CNT_W-1:0]   cnt_reg;
    logic [TICK_BITS-1:0]   dvd_reg;
    logic [PERIOD_BITS-1:0] div_reg;
    logic [PERIOD_BITS:0]   rem_reg;

    logic [TICK_BITS-1:0]   dvd_next;
    logic [PERIOD_BITS:0]   rem_next;

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        for (int k = 0; k < MOD_STEP; k++)
        begin
            rem_next = {rem_next[PERIOD_BITS-1:0], dvd_next[TICK_BITS-1]};
            dvd_next = {dvd_next[TICK_BITS-2:0], 1'b0};
            if (rem_next >= {1'b0, div_reg})
            begin
                rem_next = rem_next - {1'b0, div_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                dvd_reg <= dividend;
                div_reg <= divisor;
                rem_reg <= '0;
            end
            else if (run_reg)
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + MOD_CNT_W'(1);
                if (cnt_reg == MOD_CNT_W'(MOD_CYCLES - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[PERIOD_BITS-1:0];

endmodule

>>> bench/release_checker.sv
`timescale 1ns / 100ps
// checker for the periodic task release engine: tracks config writes, predicts each
// result word from the accepted input words and compares it with the block's output
// depends on ptrel_pkg
module release_checker
    import ptrel_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       opcode,
    input  logic [2:0]                 task_index,
    input  logic                       done,
    input  logic [TASK_COUNT-1:0]      ready_mask,
    input  logic [TASK_COUNT-1:0]      waiting_mask,
    input  logic [TASK_COUNT-1:0]      released_mask,
    input  logic [TICK_BITS-1:0]       tick_count,
    input  logic [ACTIVATION_BITS-1:0] activation_total,
    output int                         errors,
    output int                         pending
);

    typedef struct packed {
        logic [TASK_COUNT-1:0]      ready;
        logic [TASK_COUNT-1:0]      waiting;
        logic [TASK_COUNT-1:0]      released;
        logic [TICK_BITS-1:0]       tick;
        logic [ACTIVATION_BITS-1:0] activation;
    } report_t;

    logic [TABLE_W-1:0]         periods;
    logic [TABLE_W-1:0]         phases;
    logic [PRED_TABLE_W-1:0]    preds;
    logic [ACTIVE_BITS-1:0]     active_cnt;
    logic [TICK_BITS-1:0]       ticks;
    task_status_t               status [TASK_COUNT];
    logic [TASK_COUNT-1:0]      finished;
    logic [ACTIVATION_BITS-1:0] activations [TASK_COUNT];
    report_t                    pending_reports [$];

    task automatic advance_schedule(input logic op, input logic [2:0] idx);
        report_t                r;
        logic [TASK_COUNT-1:0]  fired;
        logic [TASK_COUNT-1:0]  freed;
        logic [PERIOD_BITS-1:0] per;
        logic [PRED_BITS-1:0]   p;
        logic                   has;
        int                     n;
        r = '0;
        fired = '0;
        freed = '0;
        n = (active_cnt > TASK_COUNT) ? TASK_COUNT : active_cnt;
        if (op == OP_TICK)
        begin
            ticks = ticks + TICK_BITS'(1);
            for (int i = 0; i < n; i++)
            begin
                per = periods[i*PERIOD_BITS +: PERIOD_BITS];
                fired[i] = (per != 0) &&
                           ((ticks % per) == phases[i*PERIOD_BITS +: PERIOD_BITS]);
                if (fired[i])
                begin
                    finished[i] = 1'b0;
                    if (preds[i*PRED_BITS +: PRED_BITS] == NO_PRED)
                    begin
                        status[i] = ST_READY;
                        freed[i] = 1'b1;
                    end
                end
            end
            for (int j = 0; j < n; j++)
            begin
                for (int i = 0; i < n; i++)
                begin
                    p = preds[i*PRED_BITS +: PRED_BITS];
                    has = (p != NO_PRED) && (p < n);
                    if (fired[i] && p != NO_PRED)
                    begin
                        if (has)
                        begin
                            if (status[p] == ST_READY || status[p] == ST_WAIT)
                                status[i] = ST_WAIT;
                            else if (finished[p])
                            begin
                                status[i] = ST_READY;
                                freed[i] = 1'b1;
                            end
                            else
                                status[i] = ST_WAIT;
                        end
                    end
                    else if (status[i] == ST_WAIT && has && finished[p])
                    begin
                        status[i] = ST_READY;
                        freed[i] = 1'b1;
                    end
                end
            end
        end
        else if (idx < TASK_COUNT)
        begin
            status[idx] = ST_IDLE;
            finished[idx] = 1'b1;
            if (activations[idx] != '1)
                activations[idx] = activations[idx] + ACTIVATION_BITS'(1);
            r.activation = activations[idx];
        end
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            r.ready[i] = (status[i] == ST_READY);
            r.waiting[i] = (status[i] == ST_WAIT);
        end
        r.released = freed & r.ready;
        r.tick = ticks;
        pending_reports.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t want;
        if (!rst_n)
        begin
            periods = '0;
            phases = '0;
            preds = '1;
            active_cnt = '0;
            ticks = '0;
            finished = '0;
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                status[i] = ST_IDLE;
                activations[i] = '0;
            end
            pending_reports.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("ready_mask", 32'(want.ready), 32'(ready_mask));
                    check_field("waiting_mask", 32'(want.waiting), 32'(waiting_mask));
                    check_field("released_mask", 32'(want.released), 32'(released_mask));
                    check_field("tick_count", want.tick, tick_count);
                    check_field("activation_total", 32'(want.activation),
                                32'(activation_total));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PERIOD: periods = cfg_data[TABLE_W-1:0];
                    REG_PHASE:  phases = cfg_data[TABLE_W-1:0];
                    REG_PRED:   preds = cfg_data[PRED_TABLE_W-1:0];
                    REG_ACTIVE: active_cnt = cfg_data[ACTIVE_BITS-1:0];
                    default:    ;
                endcase
            end
            if (start && !busy)
                advance_schedule(opcode, task_index);
            pending = pending_reports.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// top of the release engine testbench: clock, reset, config and input stimulus, verdict
// depends on ptrel_pkg, release_checker and periodic_task_release_with_precedence
module tb
    import ptrel_pkg::*;
();

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       start;
    logic                       busy;
    logic                       opcode;
    logic [2:0]                 task_index;
    logic                       done;
    logic [TASK_COUNT-1:0]      ready_mask;
    logic [TASK_COUNT-1:0]      waiting_mask;
    logic [TASK_COUNT-1:0]      released_mask;
    logic [TICK_BITS-1:0]       tick_count;
    logic [ACTIVATION_BITS-1:0] activation_total;
    logic [TASK_COUNT-1:0]      last_ready = '0;
    int                         errors;
    int                         pending;

    periodic_task_release_with_precedence dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .task_index       (task_index),
        .done             (done),
        .ready_mask       (ready_mask),
        .waiting_mask     (waiting_mask),
        .released_mask    (released_mask),
        .tick_count       (tick_count),
        .activation_total (activation_total)
    );

    release_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .task_index       (task_index),
        .done             (done),
        .ready_mask       (ready_mask),
        .waiting_mask     (waiting_mask),
        .released_mask    (released_mask),
        .tick_count       (tick_count),
        .activation_total (activation_total),
        .errors           (errors),
        .pending          (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (done)
            last_ready <= ready_mask;
    end

    task automatic send_word(input logic op, input logic [2:0] idx);
        opcode <= op;
        task_index <= idx;
        start <= 1'b1;
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    task automatic load_tables(input logic [TABLE_W-1:0] per, input logic [TABLE_W-1:0] pha,
                               input logic [PRED_TABLE_W-1:0] prd,
                               input logic [ACTIVE_BITS-1:0] act);
        settle();
        write_reg(REG_PERIOD, CFG_DATA_W'(per));
        write_reg(REG_PHASE, CFG_DATA_W'(pha));
        write_reg(REG_PRED, CFG_DATA_W'(prd));
        write_reg(REG_ACTIVE, CFG_DATA_W'(act));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [TABLE_W-1:0]      per;
        logic [TABLE_W-1:0]      pha;
        logic [PRED_TABLE_W-1:0] prd;
        logic [ACTIVE_BITS-1:0]  act;
        logic                    calm;
        int                      p;
        int                      t;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        start <= 1'b0;
        opcode <= OP_TICK;
        task_index <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing active yet, completions still land
        send_word(OP_TICK, 3'd0);
        send_word(OP_DONE, 3'd0);
        send_word(OP_DONE, 3'd6);
        send_word(OP_DONE, 3'd7);

        // zero period, phase past period, inactive predecessor, oversized active count
        load_tables({8'd4, 8'd255, 8'd3, 8'd0, 8'd2, 8'd2},
                    {8'd0, 8'd254, 8'd5, 8'd0, 8'd1, 8'd0},
                    {3'd1, 3'd6, NO_PRED, NO_PRED, 3'd0, NO_PRED}, 3'd7);
        send_word(OP_TICK, 3'd0);
        send_word(OP_TICK, 3'd0);
        send_word(OP_DONE, 3'd0);
        send_word(OP_TICK, 3'd0);
        send_word(OP_TICK, 3'd0);
        send_word(OP_DONE, 3'd1);
        send_word(OP_TICK, 3'd0);
        send_word(OP_DONE, 3'd5);
        send_word(OP_DONE, 3'd4);
        send_word(OP_TICK, 3'd0);
        send_word(OP_TICK, 3'd0);

        // periods and phases at their top value, every task with task 0 as its predecessor
        load_tables('1, '1, '0, 3'd6);
        send_word(OP_TICK, 3'd7);
        send_word(OP_TICK, 3'd0);
        send_word(OP_DONE, 3'd3);

        // every tick releases, short chain, two inactive tasks with predecessors outside the active set
        load_tables({6{8'd1}}, '0, {NO_PRED, 3'd4, 3'd5, 3'd1, 3'd0, NO_PRED}, 3'd3);
        send_word(OP_TICK, 3'd0);
        send_word(OP_DONE, 3'd0);
        send_word(OP_TICK, 3'd0);
        send_word(OP_DONE, 3'd1);
        send_word(OP_TICK, 3'd0);
        send_word(OP_DONE, 3'd2);
        send_word(OP_TICK, 3'd0);

        load_tables('0, '0, '0, 3'd0);
        send_word(OP_TICK, 3'd0);

        for (int ph = 0; ph < 10; ph++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                per = TABLE_W'({$urandom, $urandom});
                pha = TABLE_W'({$urandom, $urandom});
                prd = PRED_TABLE_W'($urandom);
                act = ACTIVE_BITS'($urandom_range(0, 7));
            end
            else
            begin
                for (int k = 0; k < TASK_COUNT; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        p = 0;
                    else if ($urandom_range(0, 9) == 0)
                        p = $urandom_range(9, 255);
                    else
                        p = $urandom_range(1, 8);
                    per[k*PERIOD_BITS +: PERIOD_BITS] = PERIOD_BITS'(p);
                    if (p == 0 || $urandom_range(0, 9) == 0)
                        pha[k*PERIOD_BITS +: PERIOD_BITS] = PERIOD_BITS'($urandom_range(0, 255));
                    else
                        pha[k*PERIOD_BITS +: PERIOD_BITS] = PERIOD_BITS'($urandom_range(0, p - 1));
                    if ($urandom_range(0, 1) == 0)
                        prd[k*PRED_BITS +: PRED_BITS] = NO_PRED;
                    else
                        prd[k*PRED_BITS +: PRED_BITS] = PRED_BITS'($urandom_range(0, 6));
                end
                act = ($urandom_range(0, 3) == 0) ? ACTIVE_BITS'($urandom_range(0, 7))
                                                  : ACTIVE_BITS'($urandom_range(3, 6));
            end
            load_tables(per, pha, prd, act);
            calm = (ph % 3 == 2) || (ph == 9);
            for (int k = 0; k < 165; k++)
            begin
                if (!calm && $urandom_range(0, 3) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 9)) @(posedge clk);
                end
                if ($urandom_range(0, 9) < 5)
                    send_word(OP_TICK, 3'($urandom_range(0, 7)));
                else if (last_ready != 0 && $urandom_range(0, 9) < 7)
                begin
                    do t = $urandom_range(0, TASK_COUNT - 1); while (!last_ready[t]);
                    send_word(OP_DONE, 3'(t));
                end
                else
                    send_word(OP_DONE, 3'($urandom_range(0, 7)));
            end
        end

        settle();
        repeat (120) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("periodic_task_release_with_precedence: match");
        else
            $display("periodic_task_release_with_precedence: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("periodic_task_release_with_precedence: mismatch");
        $finish;
    end

endmodule

>>> files.f
sv/ptrel_pkg.sv
sv/ptrel_mod_unit.sv
sv/periodic_task_release_with_precedence.sv
bench/release_checker.sv
bench/tb.sv
